[rtl/pidtc_pkg.sv]
// Shared types, codes and constants for the PID temperature controller.
// No dependencies; imported by pidtc_cfg, pidtc_calc, pid_temperature_controller and its testbench.

package pidtc_pkg;

  // Input function codes; code 3 is unused
  typedef enum logic [1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_START  = 2'd1,
    FUNC_STOP   = 2'd2
  } func_e;

  // Configuration register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_SETPOINT   = 2'd0,
    REG_PROP_GAIN  = 2'd1,
    REG_INTEG_GAIN = 2'd2,
    REG_DERIV_GAIN = 2'd3
  } reg_idx_e;

  localparam int unsigned FracBits = 16;

  localparam logic [6:0]  SetpointMax   = 7'd99;
  localparam logic [7:0]  DriveMax      = 8'hFF;
  localparam logic [7:0]  DriveHalf     = 8'h80;
  localparam logic [31:0] AccPreset     = {8'd0, DriveHalf, 16'd0};
  localparam logic [31:0] AccPosLimit   = 32'h7FFF_FFFF;
  localparam logic [31:0] AccNegLimit   = 32'h8000_0000;

  localparam logic [6:0]  SetpointReset = 7'd0;
  localparam logic [15:0] PropGainReset = 16'd26214;
  localparam logic [15:0] IntegGainReset = 16'd1311;
  localparam logic [15:0] DerivGainReset = 16'd32768;

  // Scale constants: goal = sp * 255 / 100, divide done as (x * 5243) >> 19
  localparam logic [14:0] FullScale  = 15'd255;
  localparam logic [27:0] RecipHund  = 28'd5243;
  localparam int unsigned RecipShift = 19;

  // Configuration seen by the datapath
  typedef struct packed {
    logic [7:0]  goal;
    logic [15:0] prop_gain;
    logic [15:0] integ_gain;
    logic [15:0] deriv_gain;
  } pidtc_cfg_t;

  // Datapath results for one sample
  typedef struct packed {
    logic signed [8:0] err;
    logic [31:0]       acc_next;
    logic [7:0]        drive;
  } pidtc_calc_t;

  // Scale a percent setpoint to the 8-bit converter range
  function automatic logic [7:0] goal_from_percent(input logic [6:0] pct);
    logic [6:0]  sp;
    logic [14:0] scaled;
    logic [27:0] prod;
    sp     = (pct > SetpointMax) ? SetpointMax : pct;
    scaled = {8'd0, sp} * FullScale;
    prod   = {13'd0, scaled} * RecipHund;
    return prod[RecipShift +: 8];
  endfunction

endpackage

[rtl/pidtc_cfg.sv]
// Configuration register file with APB-style access for the PID controller.
// Depends on pidtc_pkg for register indexes, reset values and the setpoint scaler.

module pidtc_cfg
  import pidtc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output pidtc_cfg_t  cfg_o
);

  logic [6:0]  setpoint_q, setpoint_d;
  logic [7:0]  goal_q, goal_d;
  logic [15:0] kp_q, kp_d;
  logic [15:0] ki_q, ki_d;
  logic [15:0] kd_q, kd_d;
  logic        wr_en;
  reg_idx_e    idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_e'(paddr[3:2]);

  // Decode writes; the scaled goal is refreshed with the setpoint
  always_comb begin
    setpoint_d = setpoint_q;
    goal_d     = goal_q;
    kp_d       = kp_q;
    ki_d       = ki_q;
    kd_d       = kd_q;
    if (wr_en) begin
      case (idx)
        REG_SETPOINT: begin
          setpoint_d = pwdata[6:0];
          goal_d     = goal_from_percent(pwdata[6:0]);
        end
        REG_PROP_GAIN:  kp_d = pwdata[15:0];
        REG_INTEG_GAIN: ki_d = pwdata[15:0];
        REG_DERIV_GAIN: kd_d = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q <= SetpointReset;
      goal_q     <= goal_from_percent(SetpointReset);
      kp_q       <= PropGainReset;
      ki_q       <= IntegGainReset;
      kd_q       <= DerivGainReset;
    end else begin
      setpoint_q <= setpoint_d;
      goal_q     <= goal_d;
      kp_q       <= kp_d;
      ki_q       <= ki_d;
      kd_q       <= kd_d;
    end
  end

  // Read back the addressed register
  always_comb begin
    case (idx)
      REG_SETPOINT:   prdata = {25'd0, setpoint_q};
      REG_PROP_GAIN:  prdata = {16'd0, kp_q};
      REG_INTEG_GAIN: prdata = {16'd0, ki_q};
      REG_DERIV_GAIN: prdata = {16'd0, kd_q};
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg_o.goal       = goal_q;
  assign cfg_o.prop_gain  = kp_q;
  assign cfg_o.integ_gain = ki_q;
  assign cfg_o.deriv_gain = kd_q;

endmodule

[rtl/pidtc_calc.sv]
// Combinational PID datapath: error, saturating integral update and clamped drive.
// Depends on pidtc_pkg for the configuration and result structs and limits.

module pidtc_calc
  import pidtc_pkg::*;
(
  input  pidtc_cfg_t        cfg_i,
  input  logic [7:0]        sample_i,
  input  logic signed [8:0] prev_error_i,
  input  logic [31:0]       integ_acc_i,
  output pidtc_calc_t       res_o
);

  logic signed [8:0]  err;
  logic signed [9:0]  diff;
  logic signed [24:0] p_term;
  logic signed [24:0] i_term;
  logic signed [25:0] d_term;
  logic signed [32:0] acc_sum;
  logic [31:0]        acc_next;
  logic signed [33:0] total;
  logic [7:0]         drive;

  // Error and its change since the last sample
  assign err  = $signed({1'b0, cfg_i.goal}) - $signed({1'b0, sample_i});
  assign diff = $signed({err[8], err}) - $signed({prev_error_i[8], prev_error_i});

  // Gain products; Q0.16 gains times integer error give signed Q9.16 (P, I) and Q10.16 (D) terms
  assign p_term = $signed({9'd0, cfg_i.prop_gain}) * $signed({{16{err[8]}}, err});
  assign i_term = $signed({9'd0, cfg_i.integ_gain}) * $signed({{16{err[8]}}, err});
  assign d_term = $signed({10'd0, cfg_i.deriv_gain}) * $signed({{16{diff[9]}}, diff});

  // Accumulate the integral and saturate at the 32-bit limits
  assign acc_sum = $signed({integ_acc_i[31], integ_acc_i}) + $signed({{8{i_term[24]}}, i_term});

  always_comb begin
    if (acc_sum[32] != acc_sum[31]) begin
      acc_next = acc_sum[32] ? AccNegLimit : AccPosLimit;
    end else begin
      acc_next = acc_sum[31:0];
    end
  end

  // Sum the three terms, drop the fraction and clamp to the drive range
  assign total = $signed({{2{acc_next[31]}}, acc_next})
               + $signed({{9{p_term[24]}}, p_term})
               + $signed({{8{d_term[25]}}, d_term});

  always_comb begin
    if (total[33]) begin
      drive = 8'd0;
    end else if (|total[32:FracBits+8]) begin
      drive = DriveMax;
    end else begin
      drive = total[FracBits +: 8];
    end
  end

  assign res_o.err      = err;
  assign res_o.acc_next = acc_next;
  assign res_o.drive    = drive;

endmodule

[rtl/pid_temperature_controller.sv]
// Top level of the positional PID temperature controller with clamped 8-bit drive.
// Depends on pidtc_pkg, pidtc_cfg (register file) and pidtc_calc (datapath).
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_stall_o  func_i[1:0], sample_i[7:0]
//   out      output     out_valid_o/out_stall_i drive_o[7:0]
//   cfg      input      psel/penable/pready    paddr[3:0], pwdata, prdata
//
// One transaction per cycle sustained while the output is not stalled. A transaction waits
// in the input register, where the combinational datapath (two 16x9 multiplies, one 16x10
// multiply and one add-and-clamp) runs; as it leaves, the loop state updates and its result,
// if any, is loaded into the output register.
// Reset clears the loop state, both valid flags and restores the default gains.
// The input stalls only while it holds a result-bearing transaction and the output
// register is full and stalled; start, ignored samples and unused codes never stall.

module pid_temperature_controller
  import pidtc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  sample_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  drive_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  pidtc_cfg_t  cfg;
  pidtc_calc_t calc;

  logic              s1_valid_q, s1_valid_d;
  logic [1:0]        s1_func_q;
  logic [7:0]        s1_sample_q;
  logic              running_q, running_d;
  logic [31:0]       integ_acc_q, integ_acc_d;
  logic signed [8:0] prev_error_q, prev_error_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        drive_q;
  logic              in_accept;
  logic              s1_has_result;
  logic              out_free;
  logic              s1_adv;
  logic              out_load;

  pidtc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pidtc_calc u_calc (
    .cfg_i        (cfg),
    .sample_i     (s1_sample_q),
    .prev_error_i (prev_error_q),
    .integ_acc_i  (integ_acc_q),
    .res_o        (calc)
  );

  // Pipeline control
  assign s1_has_result = (s1_func_q == FUNC_STOP) || ((s1_func_q == FUNC_SAMPLE) && running_q);
  assign out_free      = !out_valid_q || !out_stall_i;
  assign s1_adv        = s1_valid_q && (!s1_has_result || out_free);
  assign out_load      = s1_adv && s1_has_result;
  assign in_stall_o    = s1_valid_q && !s1_adv;
  assign in_accept     = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_accept || (s1_valid_q && !s1_adv);
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  // Update loop state as a transaction leaves the input register
  always_comb begin
    running_d    = running_q;
    integ_acc_d  = integ_acc_q;
    prev_error_d = prev_error_q;
    if (s1_adv) begin
      case (s1_func_q)
        FUNC_START: begin
          running_d    = 1'b1;
          integ_acc_d  = AccPreset;
          prev_error_d = '0;
        end
        FUNC_STOP: running_d = 1'b0;
        FUNC_SAMPLE: begin
          if (running_q) begin
            integ_acc_d  = calc.acc_next;
            prev_error_d = calc.err;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      running_q    <= 1'b0;
      integ_acc_q  <= '0;
      prev_error_q <= '0;
    end else begin
      s1_valid_q   <= s1_valid_d;
      out_valid_q  <= out_valid_d;
      running_q    <= running_d;
      integ_acc_q  <= integ_acc_d;
      prev_error_q <= prev_error_d;
    end
  end

  // Capture payloads
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_func_q   <= func_i;
      s1_sample_q <= sample_i;
    end
    if (out_load) begin
      drive_q <= (s1_func_q == FUNC_STOP) ? DriveHalf : calc.drive;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

  // Start presets the loop state
  a_start_preset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && (s1_func_q == FUNC_START)) |=>
      (running_q && (integ_acc_q == AccPreset) && (prev_error_q == '0)))
    else $error("start did not preset the loop state");

  // Stop halts the loop and presents the midpoint drive
  a_stop_midpoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && (s1_func_q == FUNC_STOP)) |=>
      (!running_q && out_valid_q && (drive_q == DriveHalf)))
    else $error("stop did not give the midpoint drive");

  // Input backpressure only comes from a full, stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s1_has_result && out_valid_q && out_stall_i))
    else $error("input stalled without output backpressure");

endmodule

[test/pid_temperature_controller_test.sv]
// Self-checking testbench for pid_temperature_controller: drives loop transactions and
// APB register writes, predicts every drive value, and compares results as they arrive.
// Depends on pidtc_pkg and the pid_temperature_controller RTL.

module pid_temperature_controller_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pidtc_pkg::*;

  localparam logic [1:0] FuncUnused   = 2'd3;
  localparam int         CycleLimit   = 500000;
  localparam int         LongHold     = 400;
  localparam int         SettleCycles = 8;
  localparam longint     AccCeil      = 64'sd2147483647;
  localparam longint     AccFloor     = -64'sd2147483648;

  // Loop predictor: mirrors gains, setpoint and loop state, queues expected drive values
  class drive_predictor;
    logic [7:0] pending_drive[$];
    int         mismatches = 0;
    int         checked = 0;
    logic [6:0]  setpoint;
    logic [15:0] kp, ki, kd;
    bit          running;
    int          integ;
    int          prev_err;

    function void reset_loop();
      setpoint = SetpointReset;
      kp       = PropGainReset;
      ki       = IntegGainReset;
      kd       = DerivGainReset;
      running  = 1'b0;
      integ    = 0;
      prev_err = 0;
      pending_drive.delete();
    endfunction

    function void apply_reg(reg_idx_e idx, logic [31:0] value);
      case (idx)
        REG_SETPOINT:   setpoint = value[6:0];
        REG_PROP_GAIN:  kp = value[15:0];
        REG_INTEG_GAIN: ki = value[15:0];
        REG_DERIV_GAIN: kd = value[15:0];
        default: ;
      endcase
    endfunction

    function int goal_level();
      int sp;
      sp = (setpoint > SetpointMax) ? int'(SetpointMax) : int'(setpoint);
      return sp * 255 / 100;
    endfunction

    // Advance the loop state by one accepted transaction
    function void note_transaction(logic [1:0] func, logic [7:0] smp);
      int     err;
      longint p_term, d_term, acc, sum, whole;
      case (func)
        FUNC_START: begin
          integ    = int'(DriveHalf) << FracBits;
          prev_err = 0;
          running  = 1'b1;
        end
        FUNC_STOP: begin
          running = 1'b0;
          pending_drive.push_back(DriveHalf);
        end
        FUNC_SAMPLE: begin
          if (running) begin
            err    = goal_level() - int'(smp);
            p_term = longint'(kp) * err;
            d_term = longint'(kd) * (err - prev_err);
            acc    = longint'(integ) + longint'(ki) * err;
            // saturate the integral instead of wrapping
            if (acc > AccCeil) acc = AccCeil;
            if (acc < AccFloor) acc = AccFloor;
            integ    = int'(acc);
            prev_err = err;
            sum      = p_term + acc + d_term;
            if (sum < 0) begin
              pending_drive.push_back(8'd0);
            end else begin
              whole = sum >>> FracBits;
              pending_drive.push_back((whole > 255) ? DriveMax : whole[7:0]);
            end
          end
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      mismatches++;
    endtask

    task check_drive(logic [7:0] got);
      logic [7:0] want;
      if (pending_drive.size() == 0) begin
        report($sformatf("drive %0d arrived with no value pending", got));
      end else begin
        want = pending_drive.pop_front();
        checked++;
        if (got !== want) report($sformatf("drive %0d, predicted %0d", got, want));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  func = FUNC_SAMPLE;
  logic [7:0]  sample = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  drive;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  int cycle_count = 0;
  int items_done = 0;
  int settings_used = 0;
  bit idle_off = 1'b0;
  bit hold_req = 1'b0;

  drive_predictor tracker = new;

  pid_temperature_controller uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .func_i      (func),
    .sample_i    (sample),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .drive_o     (drive),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Abort a hung run
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Timeout after %0d cycles", cycle_count);
    $display("*** FAILED ***");
    $finish;
  end

  // Offer one transaction after a random gap (none while idle_off is set) and hold it until accepted
  task automatic offer(logic [1:0] f, logic [7:0] smp);
    int gap;
    gap = idle_off ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    sample   <= smp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (f == FUNC_START || f == FUNC_STOP || (f == FUNC_SAMPLE && tracker.running))
      items_done++;
    tracker.note_transaction(f, smp);
  endtask

  // Drop valid, wait until every predicted drive has come, then let the design settle
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending_drive.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // APB write: setup, access, then idle
  task automatic apb_write(reg_idx_e idx, logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.apply_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic write_all(logic [6:0] sp, logic [15:0] p, logic [15:0] i, logic [15:0] d);
    apb_write(REG_SETPOINT, {25'd0, sp});
    apb_write(REG_PROP_GAIN, {16'd0, p});
    apb_write(REG_INTEG_GAIN, {16'd0, i});
    apb_write(REG_DERIV_GAIN, {16'd0, d});
    settings_used++;
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 4095));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [6:0] pick_setpoint();
    case ($urandom_range(0, 4))
      0: return 7'd0;
      1: return SetpointMax;
      2: return 7'($urandom_range(100, 127));
      default: return 7'($urandom_range(0, 99));
    endcase
  endfunction

  // Sample shaping: 0 uniform, 1 cold, 2 hot, 3 around the goal
  function automatic logic [7:0] pick_sample(int mode);
    int g;
    case (mode)
      1: return 8'($urandom_range(0, 15));
      2: return 8'($urandom_range(240, 255));
      3: begin
        g = tracker.goal_level() + $urandom_range(0, 16) - 8;
        if (g < 0) g = 0;
        if (g > 255) g = 255;
        return 8'(g);
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One run of the loop: start, mostly samples with shaped content, some noise, stop
  task automatic run_phase(int count, int mode_fixed);
    int mode, left_in_mode, done_at, r;
    done_at      = items_done + count;
    left_in_mode = 0;
    mode         = 0;
    offer(FUNC_START, 8'($urandom));
    while (items_done < done_at) begin
      if (left_in_mode == 0) begin
        mode         = (mode_fixed >= 0) ? mode_fixed : $urandom_range(0, 3);
        left_in_mode = $urandom_range(10, 200);
      end
      left_in_mode--;
      r = $urandom_range(0, 99);
      if (r < 4) begin
        offer(FuncUnused, 8'($urandom));
      end else if (mode_fixed < 0 && r < 6) begin
        // break the sequence: stop, a sample that is ignored, then restart
        offer(FUNC_STOP, 8'($urandom));
        offer(FUNC_SAMPLE, 8'($urandom));
        offer(FUNC_START, 8'($urandom));
      end else if (mode_fixed < 0 && r < 7) begin
        offer(FUNC_START, 8'($urandom));
      end else begin
        offer(FUNC_SAMPLE, pick_sample(mode));
      end
    end
    offer(FUNC_STOP, 8'($urandom));
  endtask

  // Result side: random stall before each transaction, long hold on request
  initial begin
    int n;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LongHold) @(posedge clk);
      end
      n = idle_off ? 0 : $urandom_range(0, 19);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      tracker.check_drive(drive);
    end
  end

  // Main sequence
  initial begin
    tracker.reset_loop();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: reset gains, stopped and running cases, unused code, restart, double stop
    offer(FUNC_SAMPLE, 8'hFF);
    offer(FuncUnused, 8'h00);
    offer(FUNC_STOP, 8'h00);
    offer(FUNC_START, 8'hFF);
    offer(FUNC_SAMPLE, 8'h00);
    offer(FUNC_SAMPLE, 8'hFF);
    offer(FUNC_SAMPLE, 8'h00);
    offer(FUNC_SAMPLE, 8'h00);
    offer(FuncUnused, 8'hAA);
    offer(FUNC_SAMPLE, 8'h55);
    offer(FUNC_SAMPLE, 8'hAA);
    offer(FUNC_START, 8'h00);
    offer(FUNC_SAMPLE, 8'h01);
    offer(FUNC_SAMPLE, 8'h80);
    offer(FUNC_STOP, 8'hFF);
    offer(FUNC_STOP, 8'h00);
    offer(FUNC_SAMPLE, 8'h00);
    settle();
    // full setpoint drives the output into the top clamp
    apb_write(REG_SETPOINT, 32'd99);
    offer(FUNC_START, 8'h00);
    offer(FUNC_SAMPLE, 8'h00);
    offer(FUNC_SAMPLE, 8'hFF);
    offer(FUNC_STOP, 8'h00);
    settle();
    // setpoint above the legal range behaves as the maximum
    apb_write(REG_SETPOINT, 32'd127);
    offer(FUNC_START, 8'h00);
    offer(FUNC_SAMPLE, 8'h00);
    offer(FUNC_SAMPLE, 8'd252);
    offer(FUNC_STOP, 8'h00);
    settle();

    // Saturate the integral upward, then downward with no idling
    write_all(SetpointMax, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(160, 1);
    settle();
    idle_off = 1'b1;
    write_all(7'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(160, 2);
    settle();
    idle_off = 1'b0;
    write_all(7'd127, 16'd0, 16'd0, 16'd0);
    run_phase(110, -1);
    settle();

    // Random settings; one phase holds the result side off while input keeps coming
    for (int ph = 0; ph < 8; ph++) begin
      write_all(pick_setpoint(), pick_gain(), pick_gain(), pick_gain());
      idle_off = (ph == 2) || (ph == 5);
      if (ph == 2) hold_req = 1'b1;
      run_phase(140, -1);
      settle();
    end
    idle_off = 1'b0;

    $display("Ran %0d counted loop transactions across %0d register settings.",
             items_done, settings_used + 3);
    $display("Checked %0d drive values, %0d mismatches.", tracker.checked, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/pidtc_pkg.sv
rtl/pidtc_cfg.sv
rtl/pidtc_calc.sv
rtl/pid_temperature_controller.sv
test/pid_temperature_controller_test.sv
